FILE: design/tmwc_pkg.sv
package tmwc_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_START,
    ST_CHECK,
    ST_SCAN,
    ST_FLUSH,
    ST_CALC,
    ST_DECIDE,
    ST_PUSH
  } state_t;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [1:0] CLASS_BG  = 2'd0;
  localparam logic [1:0] CLASS_UNK = 2'd1;
  localparam logic [1:0] CLASS_FG  = 2'd2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRONG_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COVERAGE_PERCENT = 3'd4;

  localparam logic [11:0] RST_FRAME_WIDTH      = 12'd640;
  localparam logic [11:0] RST_FRAME_HEIGHT     = 12'd480;
  localparam logic [4:0]  RST_WINDOW_RADIUS    = 5'd3;
  localparam logic [7:0]  RST_STRONG_THRESHOLD = 8'd204;
  localparam logic [6:0]  RST_COVERAGE_PERCENT = 7'd1;

  typedef struct packed {
    logic accept;
    logic start;
    logic check;
    logic scan;
    logic calc;
    logic decide;
    logic push;
  } dp_cmd_t;

  typedef struct packed {
    logic emit_req;
    logic early;
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage

FILE: design/tmwc_pix_if.sv
interface tmwc_pix_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] mask_value;
  logic [7:0] fore_prob;

  modport source(output valid, output operation, output mask_value, output fore_prob,
                 input ready);
  modport sink(input valid, input operation, input mask_value, input fore_prob,
               output ready);
endinterface

FILE: design/tmwc_tri_if.sv
interface tmwc_tri_if;
  logic       valid;
  logic       ready;
  logic [1:0] trimap_class;
  logic       last_of_frame;

  modport source(output valid, output trimap_class, output last_of_frame, input ready);
  modport sink(input valid, input trimap_class, input last_of_frame, output ready);
endinterface

FILE: design/tmwc_cfg_if.sv
interface tmwc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [11:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

FILE: design/trimap_from_mask_window_count.sv
// Sequence: a beat that completes a result skips the window scan when the pixel is
//   foreground or its window is empty; otherwise it reads one window entry per cycle
//   (up to (2*R)^2 entries), which is set by the single read port of the line store.
// Throughput: one beat at a time; a new beat is taken only once the last one is done,
//   including any wait for the output register to free.
// Reset: synchronous, active high; counters clear and config registers take their defaults.
//   The line store is not cleared; only rows of the current frame are ever read.
module trimap_from_mask_window_count
  import tmwc_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  parameter int MAX_RADIUS = 16
) (
  input logic    clk,
  input logic    rst,
  tmwc_pix_if.sink   pixels,
  tmwc_tri_if.source trimap,
  tmwc_cfg_if.sink   cfg
);
  dp_cmd_t    cmd;
  dp_status_t status;

  // Config beats are always taken; the host must write only while the block is idle (unchecked).
  assign cfg.ready = 1'b1;

  // The controller sequences each beat: accept, decide whether a result is owed, then
  // read the strong bit, scan the clipped window if it is clear and not empty, and classify.
  tmwc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixels.valid),
    .in_ready (pixels.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the ring line store, the frame counters, the window scanner
  // and the output register that lets the sink stall without blocking a new beat.
  tmwc_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .operation  (pixels.operation),
    .mask_value (pixels.mask_value),
    .fore_prob  (pixels.fore_prob),
    .cfg_valid  (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .out_valid  (trimap.valid),
    .out_ready  (trimap.ready),
    .out_class  (trimap.trimap_class),
    .out_last   (trimap.last_of_frame)
  );
endmodule

FILE: design/tmwc_ram.sv
module tmwc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: design/tmwc_ctrl.sv
module tmwc_ctrl
  import tmwc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_EVAL;
      ST_EVAL:   state_next = status.emit_req ? ST_START : ST_IDLE;
      ST_START:  state_next = ST_CHECK;
      ST_CHECK:  state_next = status.early ? ST_PUSH : ST_SCAN;
      ST_SCAN:   if (status.scan_last) state_next = ST_FLUSH;
      ST_FLUSH:  state_next = ST_CALC;
      ST_CALC:   state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_PUSH;
      ST_PUSH:   if (status.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state == ST_IDLE);
    cmd        = '0;
    cmd.accept = (state == ST_IDLE) && in_valid;
    cmd.start  = (state == ST_START);
    cmd.check  = (state == ST_CHECK);
    cmd.scan   = (state == ST_SCAN);
    cmd.calc   = (state == ST_CALC);
    cmd.decide = (state == ST_DECIDE);
    cmd.push   = (state == ST_PUSH) && status.out_free;
  end
endmodule

FILE: design/tmwc_dp.sv
module tmwc_dp
  import tmwc_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  parameter int MAX_RADIUS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  input  logic                  operation,
  input  logic [7:0]            mask_value,
  input  logic [7:0]            fore_prob,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_class,
  output logic                  out_last
);
  localparam int RING = 2 * MAX_RADIUS + 2;
  localparam int SW   = $clog2(RING);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int RDW  = $clog2(MAX_RADIUS + 1);
  localparam int XW   = $clog2(MAX_WIDTH + MAX_RADIUS);
  localparam int YW   = $clog2(MAX_HEIGHT + MAX_RADIUS);
  localparam int DEPTH = RING * MAX_WIDTH;
  localparam int AW   = $clog2(DEPTH);
  localparam int PW   = $clog2(MAX_WIDTH * (MAX_RADIUS + 1) + 2);
  localparam int DW   = $clog2(2 * MAX_RADIUS + 1);
  localparam int ARW  = 2 * DW;
  localparam int CNTW = $clog2(4 * MAX_RADIUS * MAX_RADIUS + 1);
  localparam int CMPW = ((CNTW > ARW) ? CNTW : ARW) + 7;

  // Configuration registers.
  logic [11:0] cfg_w, cfg_h;
  logic [4:0]  cfg_r;
  logic [7:0]  cfg_thr;
  logic [6:0]  cfg_cov;

  logic [WW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;
  logic [RDW-1:0] r_eff;
  logic [PW-1:0]  lag;

  // Frame position state.
  logic [CW-1:0] in_col, out_col;
  logic [RW-1:0] in_row, out_row;
  logic [SW-1:0] in_slot, out_slot;
  logic [PW-1:0] pend;
  logic          frame_done, out_done, emit_req;

  // Window scan state.
  logic [XW-1:0]   x1, x2, x;
  logic [YW-1:0]   y1, y2, y;
  logic [SW-1:0]   ys;
  logic [CNTW-1:0] cnt;
  logic            rd_pend;
  logic [ARW-1:0]  area;
  logic [CMPW-1:0] cnt100;
  logic [1:0]      cls;

  // Memory port.
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [1:0]    ram_wdata, ram_rdata;

  // Combinational helpers.
  logic [CW-1:0] base_col;
  logic [RW-1:0] base_row;
  logic [SW-1:0] base_slot;
  logic [PW-1:0] base_pend;
  logic          mask_bit, strong_bit, empty, last_now;
  logic [31:0]   cr, wl, rr, hl, dd;
  logic [XW-1:0] gx1, gx2;
  logic [YW-1:0] gy1, gy2;
  logic [SW-1:0] gys;

  always_comb begin
    w_eff = (cfg_w == 12'd0) ? WW'(1) :
            (32'(cfg_w) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_w);
    h_eff = (cfg_h == 12'd0) ? HW'(1) :
            (32'(cfg_h) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_h);
    r_eff = (cfg_r == 5'd0) ? RDW'(1) :
            (32'(cfg_r) > MAX_RADIUS) ? RDW'(MAX_RADIUS) : RDW'(cfg_r);
    lag   = PW'((32'(r_eff) + 32'd1) * 32'(w_eff));
  end

  always_comb begin
    base_col   = frame_done ? '0 : in_col;
    base_row   = frame_done ? '0 : in_row;
    base_slot  = frame_done ? '0 : in_slot;
    base_pend  = frame_done ? '0 : pend;
    mask_bit   = (mask_value != 8'd0);
    strong_bit = mask_bit && (fore_prob >= cfg_thr);
    last_now   = (32'(out_row) + 32'd1 == 32'(h_eff)) &&
                 (32'(out_col) + 32'd1 == 32'(w_eff));
  end

  // Clipped half-open window of the pixel about to be classified.
  always_comb begin
    cr  = 32'(out_col) + 32'(r_eff);
    wl  = 32'(w_eff) - 32'd1;
    rr  = 32'(out_row) + 32'(r_eff);
    hl  = 32'(h_eff) - 32'd1;
    gx1 = (32'(out_col) >= 32'(r_eff)) ? XW'(32'(out_col) - 32'(r_eff)) : '0;
    gx2 = XW'((cr < wl) ? cr : wl);
    gy1 = (32'(out_row) >= 32'(r_eff)) ? YW'(32'(out_row) - 32'(r_eff)) : '0;
    gy2 = YW'((rr < hl) ? rr : hl);
    dd  = 32'(out_row) - 32'(gy1);
    gys = (32'(out_slot) >= dd) ? SW'(32'(out_slot) - dd) : SW'(32'(out_slot) + RING - dd);
    empty = (x2 <= x1) || (y2 <= y1);
  end

  always_comb begin
    ram_we    = cmd.accept && (operation == OP_PIXEL);
    ram_waddr = AW'(32'(base_slot) * MAX_WIDTH + 32'(base_col));
    ram_wdata = {strong_bit, mask_bit};
    ram_raddr = cmd.start ? AW'(32'(out_slot) * MAX_WIDTH + 32'(out_col))
                          : AW'(32'(ys) * MAX_WIDTH + 32'(x));
  end

  tmwc_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    status.emit_req  = emit_req;
    status.early     = ram_rdata[1] || empty;
    status.scan_last = (32'(x) + 32'd1 == 32'(x2)) && (32'(y) + 32'd1 == 32'(y2));
    status.out_free  = !out_valid || out_ready;
  end

  // Configuration, frame counters and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w      <= RST_FRAME_WIDTH;
      cfg_h      <= RST_FRAME_HEIGHT;
      cfg_r      <= RST_WINDOW_RADIUS;
      cfg_thr    <= RST_STRONG_THRESHOLD;
      cfg_cov    <= RST_COVERAGE_PERCENT;
      in_col     <= '0;
      in_row     <= '0;
      in_slot    <= '0;
      out_col    <= '0;
      out_row    <= '0;
      out_slot   <= '0;
      pend       <= '0;
      frame_done <= 1'b0;
      out_done   <= 1'b0;
      emit_req   <= 1'b0;
      out_valid  <= 1'b0;
      rd_pend    <= 1'b0;
    end else begin
      rd_pend <= cmd.scan;
      if (cfg_valid && (cfg_index <= REG_COVERAGE_PERCENT)) begin
        case (cfg_index)
          REG_FRAME_WIDTH:      cfg_w   <= cfg_data;
          REG_FRAME_HEIGHT:     cfg_h   <= cfg_data;
          REG_WINDOW_RADIUS:    cfg_r   <= cfg_data[4:0];
          REG_STRONG_THRESHOLD: cfg_thr <= cfg_data[7:0];
          REG_COVERAGE_PERCENT: cfg_cov <= cfg_data[6:0];
          default: ;
        endcase
        in_col     <= '0;
        in_row     <= '0;
        in_slot    <= '0;
        out_col    <= '0;
        out_row    <= '0;
        out_slot   <= '0;
        pend       <= '0;
        frame_done <= 1'b0;
        out_done   <= 1'b0;
      end else if (cmd.accept) begin
        if (operation == OP_PIXEL) begin
          emit_req <= (32'(base_pend) + 32'd1 > 32'(lag));
          pend     <= base_pend + PW'(1);
          if (frame_done) begin
            out_col  <= '0;
            out_row  <= '0;
            out_slot <= '0;
            out_done <= 1'b0;
          end
          if (32'(base_col) + 32'd1 == 32'(w_eff)) begin
            in_col <= '0;
            if (32'(base_row) + 32'd1 == 32'(h_eff)) begin
              in_row     <= '0;
              in_slot    <= '0;
              frame_done <= 1'b1;
            end else begin
              in_row     <= base_row + RW'(1);
              in_slot    <= (32'(base_slot) + 32'd1 == RING) ? '0 : base_slot + SW'(1);
              frame_done <= 1'b0;
            end
          end else begin
            in_col     <= base_col + CW'(1);
            in_row     <= base_row;
            in_slot    <= base_slot;
            frame_done <= 1'b0;
          end
        end else begin
          emit_req <= frame_done && !out_done;
        end
      end else if (cmd.push) begin
        pend <= pend - PW'(1);
        if (last_now) begin
          out_done <= 1'b1;
        end
        if (32'(out_col) + 32'd1 == 32'(w_eff)) begin
          out_col  <= '0;
          out_row  <= out_row + RW'(1);
          out_slot <= (32'(out_slot) + 32'd1 == RING) ? '0 : out_slot + SW'(1);
        end else begin
          out_col <= out_col + CW'(1);
        end
      end
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_class <= cls;
      out_last  <= last_now;
    end
  end

  // Window scan: one mask bit read per cycle, each summed in the following cycle.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x1  <= gx1;
      x2  <= gx2;
      y1  <= gy1;
      y2  <= gy2;
      x   <= gx1;
      y   <= gy1;
      ys  <= gys;
      cnt <= '0;
    end else begin
      if (cmd.scan) begin
        if (32'(x) + 32'd1 == 32'(x2)) begin
          x  <= x1;
          y  <= y + YW'(1);
          ys <= (32'(ys) + 32'd1 == RING) ? '0 : ys + SW'(1);
        end else begin
          x <= x + XW'(1);
        end
      end
      if (rd_pend) begin
        cnt <= cnt + CNTW'(ram_rdata[0]);
      end
    end
    if (cmd.check) begin
      cls <= ram_rdata[1] ? CLASS_FG : CLASS_BG;
    end
    if (cmd.calc) begin
      area   <= ARW'(DW'(x2 - x1)) * ARW'(DW'(y2 - y1));
      cnt100 <= CMPW'(cnt) * CMPW'(100);
    end
    if (cmd.decide) begin
      cls <= ((cnt != '0) && (cnt100 >= CMPW'(cfg_cov) * CMPW'(area))) ? CLASS_UNK
                                                                       : CLASS_BG;
    end
  end

  // The backlog never runs more than one pixel past the lag.
  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    32'(pend) <= 32'(lag) + 32'd1)
    else $error("pending pixel count exceeds the lag");

  // A result is only loaded when the output register can take it.
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (!out_valid || out_ready))
    else $error("result overwrote a waiting beat");

  // Delivering the final pixel marks the frame as fully drained.
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (cmd.push && last_now && !cfg_valid) |=> out_done)
    else $error("frame not marked drained after its final pixel");
endmodule
